[design/lsd_pkg.sv]
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants of the subexpression dedup table
// Field widths, result codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int OPCODE_W   = 8;
  localparam int TYPE_W     = 16;
  localparam int OPTY_W     = OPCODE_W + TYPE_W;
  localparam int FIELD_ID_W = 16;
  localparam int COUNT_W    = 3;
  localparam int FIELD_OPS  = 4;

  // Table generation tag; a stored tag of zero always means empty.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

  typedef enum logic [1:0] {
    OUT_SKIP = 2'd0,
    OUT_NEW  = 2'd1,
    OUT_DUP  = 2'd2,
    OUT_FULL = 2'd3
  } outcome_t;

  typedef struct packed {
    logic load;    // latch the accepted item
    logic sweep;   // clear one table entry
    logic hash;    // start probing at the hashed slot
    logic read;    // read the table at the probe slot
    logic next;    // advance to the following slot
    logic finish;  // write the result, insert on a miss
  } lsd_cmd_t;

  typedef struct packed {
    logic wrap;        // incoming block start exhausts the tags
    logic sweep_last;  // clearing pass is at its last entry
    logic skip;        // latched item is not tracked
    logic more;        // probe must continue
    logic out_free;    // result register can take a result
  } lsd_stat_t;

endpackage

[design/lsd_in_if.sv]
// ----------------------------------------------------------------------------
// lsd_in_if: instruction channel
// Valid/ready channel carrying one instruction description per item.
// ----------------------------------------------------------------------------
interface lsd_in_if import lsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  block_start;
  logic [FIELD_ID_W-1:0] inst_id;
  logic [OPCODE_W-1:0]   opcode;
  logic [TYPE_W-1:0]     type_id;
  logic [COUNT_W-1:0]    operand_count;
  logic [FIELD_ID_W-1:0] operand_0;
  logic [FIELD_ID_W-1:0] operand_1;
  logic [FIELD_ID_W-1:0] operand_2;
  logic [FIELD_ID_W-1:0] operand_3;
  logic                  commutative;
  logic                  phi_or_terminator;
  logic                  side_effect_or_memory;

  modport source (
    output valid, block_start, inst_id, opcode, type_id, operand_count,
           operand_0, operand_1, operand_2, operand_3, commutative,
           phi_or_terminator, side_effect_or_memory,
    input  ready
  );
  modport sink (
    input  valid, block_start, inst_id, opcode, type_id, operand_count,
           operand_0, operand_1, operand_2, operand_3, commutative,
           phi_or_terminator, side_effect_or_memory,
    output ready
  );
  modport mon (
    input valid, ready, block_start, inst_id, opcode, type_id, operand_count,
          operand_0, operand_1, operand_2, operand_3, commutative,
          phi_or_terminator, side_effect_or_memory
  );
endinterface

[design/lsd_out_if.sv]
// ----------------------------------------------------------------------------
// lsd_out_if: result channel
// Valid/ready channel carrying one lookup result per item.
// ----------------------------------------------------------------------------
interface lsd_out_if import lsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  outcome_t              outcome;
  logic [FIELD_ID_W-1:0] previous_id;

  modport source (output valid, outcome, previous_id, input ready);
  modport sink   (input valid, outcome, previous_id, output ready);
  modport mon    (input valid, ready, outcome, previous_id);
endinterface

[design/lsd_ctrl.sv]
// ----------------------------------------------------------------------------
// lsd_ctrl: sequencing of the dedup table
// Runs the clearing pass, accepts an item, and steps the hashed probe loop.
// ----------------------------------------------------------------------------
module lsd_ctrl import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsd_stat_t stat,
  output lsd_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CMP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = pend_r ? ST_HASH : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // Running out of tags forces a clearing pass before the item goes on.
          if (stat.wrap) begin
            state_nxt = ST_SWEEP;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (stat.skip) begin
          state_nxt = ST_CMP;
        end else begin
          cmd.hash  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.more) begin
          cmd.next  = 1'b1;
          state_nxt = ST_READ;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[design/lsd_dpath.sv]
// ----------------------------------------------------------------------------
// lsd_dpath: key formation, hashed table and result register
// Holds the item key, the probe pointer, the tagged entry memory, the fill
// count and the result register.
// ----------------------------------------------------------------------------
module lsd_dpath import lsd_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_OPERANDS  = 4,
  parameter int ID_BITS       = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lsd_in_if.sink        in_item,
  lsd_out_if.source     out_item,
  input  lsd_cmd_t      cmd,
  output lsd_stat_t     stat
);

  localparam int KW     = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W  = OPTY_W + COUNT_W + MAX_OPERANDS * KW;
  localparam int ENT_W  = EPOCH_W + KEY_W + KW;
  localparam int NCHUNK = (KEY_W + IDX_W - 1) / IDX_W;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FULL_LVL = FILL_W'(TABLE_ENTRIES);

  logic [ENT_W-1:0] mem [TABLE_ENTRIES];

  logic [KEY_W-1:0]   key_r;
  logic [KW-1:0]      owner_r;
  logic               skip_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [FILL_W-1:0]  fill_r;
  logic [IDX_W-1:0]   sweep_r;
  logic [IDX_W-1:0]   probe_r;
  logic [IDX_W-1:0]   pcnt_r;
  logic [ENT_W-1:0]   rdata_r;
  logic               out_valid_r;
  outcome_t           outcome_r;
  logic [FIELD_ID_W-1:0] prev_r;

  // Key of the incoming item.
  logic [FIELD_ID_W-1:0] fops [FIELD_OPS];
  logic [KW-1:0]         ops  [MAX_OPERANDS];
  logic [KEY_W-1:0]      key_in;
  logic                  swap;

  always_comb begin
    fops[0] = in_item.operand_0;
    fops[1] = in_item.operand_1;
    fops[2] = in_item.operand_2;
    fops[3] = in_item.operand_3;
    for (int i = 0; i < MAX_OPERANDS; i++) begin
      ops[i] = (COUNT_W'(i) < in_item.operand_count) ? fops[i][KW-1:0] : '0;
    end
    swap = in_item.commutative && (in_item.operand_count == COUNT_W'(2)) &&
           (ops[0] > ops[1]);
    key_in = '0;
    key_in[KEY_W-1 -: OPTY_W]           = {in_item.opcode, in_item.type_id};
    key_in[KEY_W-OPTY_W-1 -: COUNT_W]   = in_item.operand_count;
    for (int i = 0; i < MAX_OPERANDS; i++) begin
      key_in[i*KW +: KW] = ops[i];
    end
    if (swap) begin
      key_in[0 +: KW]  = ops[1];
      key_in[KW +: KW] = ops[0];
    end
  end

  // XOR fold of the key, reduced into the table range.
  logic [NCHUNK*IDX_W-1:0] key_pad;
  logic [IDX_W-1:0]        hfold;
  logic [IDX_W-1:0]        hslot;

  always_comb begin
    key_pad = '0;
    key_pad[KEY_W-1:0] = key_r;
    hfold = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      hfold = hfold ^ key_pad[c*IDX_W +: IDX_W];
    end
    if ({1'b0, hfold} >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      hslot = hfold - IDX_W'(TABLE_ENTRIES);
    end else begin
      hslot = hfold;
    end
  end

  // Probe evaluation on the registered entry.
  logic [EPOCH_W-1:0] rd_epoch;
  logic [KEY_W-1:0]   rd_key;
  logic [KW-1:0]      rd_owner;
  logic               empty, hit, room, insert;

  assign rd_epoch = rdata_r[ENT_W-1 -: EPOCH_W];
  assign rd_key   = rdata_r[KW +: KEY_W];
  assign rd_owner = rdata_r[KW-1:0];
  assign empty    = (rd_epoch != epoch_r);
  assign hit      = !empty && (rd_key == key_r);
  assign room     = (fill_r < FULL_LVL);
  assign insert   = cmd.finish && !skip_r && !hit && empty && room;

  assign stat.wrap       = in_item.block_start && (epoch_r == EPOCH_LAST);
  assign stat.sweep_last = (sweep_r == LAST_IDX);
  assign stat.skip       = skip_r;
  assign stat.more       = !skip_r && !empty && !hit && (pcnt_r != LAST_IDX);
  assign stat.out_free   = !out_valid_r || out_item.ready;

  outcome_t              res_outcome;
  logic [FIELD_ID_W-1:0] res_prev;

  always_comb begin
    res_prev = '0;
    if (skip_r) begin
      res_outcome = OUT_SKIP;
    end else if (hit) begin
      res_outcome = OUT_DUP;
      res_prev[KW-1:0] = rd_owner;
    end else if (empty && room) begin
      res_outcome = OUT_NEW;
    end else begin
      res_outcome = OUT_FULL;
    end
  end

  // Table memory: one write port shared by the clearing pass and inserts.
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_r] <= {EPOCH_NONE, {(KEY_W + KW){1'b0}}};
    end else if (insert) begin
      mem[probe_r] <= {epoch_r, key_r, owner_r};
    end
    if (cmd.read) begin
      rdata_r <= mem[probe_r];
    end
  end

  // Item and probe registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= key_in;
      owner_r <= in_item.inst_id[KW-1:0];
      skip_r  <= in_item.phi_or_terminator || in_item.side_effect_or_memory ||
                 (in_item.operand_count > COUNT_W'(MAX_OPERANDS));
    end
    if (cmd.hash) begin
      probe_r <= hslot;
      pcnt_r  <= '0;
    end else if (cmd.next) begin
      probe_r <= (probe_r == LAST_IDX) ? '0 : probe_r + 1'b1;
      pcnt_r  <= pcnt_r + 1'b1;
    end
    if (cmd.finish) begin
      outcome_r <= res_outcome;
      prev_r    <= res_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= EPOCH_FIRST;
      fill_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_item.block_start) begin
        fill_r  <= '0;
        epoch_r <= (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + 1'b1;
      end else if (insert) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.sweep) begin
        sweep_r <= (sweep_r == LAST_IDX) ? '0 : sweep_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.outcome     = outcome_r;
  assign out_item.previous_id = prev_r;

endmodule

[design/local_subexpression_dedup_table_core.sv]
// ----------------------------------------------------------------------------
// local_subexpression_dedup_table_core: local value numbering table
// Forms a key per instruction, looks it up in a hashed table cleared at each
// block start, and reports skipped, new, duplicate or table full.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  in_item    in   valid / ready    instruction description
//  out_item   out  valid / ready    outcome, previous_id
//
//  A tracked item is hashed, then takes a read and a compare step per slot
//  probed, with linear probing over one read port of the entry memory; a
//  skipped item goes from the hash step straight to its result.
//  After reset, a clearing pass over all TABLE_ENTRIES entries runs before
//  the first item is taken; every 255th block start runs the same pass first.
//  A held result stalls only the item behind it, at its last step.
// ----------------------------------------------------------------------------
module local_subexpression_dedup_table_core import lsd_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_OPERANDS  = 4,
  parameter int ID_BITS       = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lsd_in_if.sink    in_item,
  lsd_out_if.source out_item
);

  lsd_cmd_t  cmd;
  lsd_stat_t stat;
  logic      ctl_ready;

  assign in_item.ready = ctl_ready;

  lsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (ctl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsd_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_OPERANDS  (MAX_OPERANDS),
    .ID_BITS       (ID_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

[design/lsd_checker.sv]
// ----------------------------------------------------------------------------
// lsd_checker: port level checks of the dedup table
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
module lsd_checker import lsd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  lsd_in_if.sink    in_item,
  lsd_out_if.source out_item
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && !out_item.ready |=>
      out_item.valid && $stable(out_item.outcome) && $stable(out_item.previous_id))
    else $error("result changed while stalled");

  // Only a duplicate carries an earlier instruction id.
  a_prev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && (out_item.outcome != OUT_DUP) |-> out_item.previous_id == '0)
    else $error("previous_id set on a non-duplicate result");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> !in_item.ready)
    else $error("item taken while another is in progress");

  // Reset leaves no result pending and takes no item.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_item.valid && !in_item.ready)
    else $error("activity right after reset");

endmodule

bind local_subexpression_dedup_table_core lsd_checker u_lsd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_item  (in_item),
  .out_item (out_item)
);
